// ===== sv/tcsg_pkg.sv =====
// Shared types and constants for the touch circle span generator.
// No dependencies; every other file in sv/ refers to it by scoped names.
package tcsg_pkg;

  // Coordinate and arithmetic widths
  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned SW           = COORD_BITS + 3;  // signed work width
  localparam int unsigned MAX_DIAMETER = 64;
  localparam int unsigned DIAM_W       = 7;
  localparam int unsigned H_W          = 6;   // half-side 0..32
  localparam int unsigned R2_W         = 11;  // radius squared 0..1024
  localparam int unsigned REM_W        = 12;  // signed remainder
  localparam int unsigned DY_W         = 7;   // signed row offset
  localparam int unsigned SQ_W         = 2 * H_W;
  localparam int unsigned CNT_W        = 2;
  localparam int unsigned COLS_W       = 13;
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned CODE_W       = 16;
  localparam int unsigned CFG_IDX_W    = 2;

  // Event codes
  localparam logic [CODE_W-1:0] CODE_COL = 16'd53;
  localparam logic [CODE_W-1:0] CODE_ROW = 16'd54;

  localparam logic [CNT_W-1:0] TOUCH_MAX  = 2'd3;
  localparam logic [CNT_W-1:0] TOUCH_DRAW = 2'd2;

  localparam logic [DIAM_W-1:0]  DIAM_LIMIT = DIAM_W'(MAX_DIAMETER);
  localparam logic signed [SW-1:0] COORD_MAX_S = SW'((1 << COORD_BITS) - 1);

  // Register reset values
  localparam logic [DIAM_W-1:0]  DIAM_RST  = 7'd30;
  localparam logic [COLS_W-1:0]  COLS_RST  = 13'd800;
  localparam logic [COLS_W-1:0]  ROWS_RST  = 13'd480;
  localparam logic [COLOR_W-1:0] COLOR_RST = 24'hFF0000;

  // Result kinds
  localparam logic KIND_SPAN  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Command queue
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = 1;
  localparam int unsigned CMD_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIAMETER = 2'd0,
    CFG_COLS     = 2'd1,
    CFG_ROWS     = 2'd2,
    CFG_COLOR    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DIAM_W-1:0]  diameter;
    logic [COLS_W-1:0]  cols;
    logic [COLS_W-1:0]  rows;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  // One queued job: either a clear or a draw around a captured centre
  typedef struct packed {
    logic                  is_clear;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_CLR   = 3'd1,
    B_INIT  = 3'd2,
    B_ROW   = 3'd3,
    B_DX    = 3'd4,
    B_SPAN  = 3'd5,
    B_FLUSH = 3'd6
  } back_state_e;

endpackage

// ===== sv/tcsg_front.sv =====
// Front end: takes touch events, tracks the centre and touch count, and
// queues clear or draw jobs. Depends on tcsg_pkg.
module tcsg_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tcsg_pkg::CODE_W-1:0]     event_code_i,
  input  logic [tcsg_pkg::COORD_BITS-1:0] event_value_i,
  input  logic                            clear_pressed_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output tcsg_pkg::cmd_t                  q_cmd_o
);

  logic [tcsg_pkg::COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [tcsg_pkg::CNT_W-1:0]      touch_q, touch_d, count_nx;
  logic                            accept, draw;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    count_nx = touch_q;
    if (event_code_i == tcsg_pkg::CODE_COL) begin
      col_d = event_value_i;
      if (touch_q != tcsg_pkg::TOUCH_MAX) count_nx = touch_q + 2'd1;
    end else if (event_code_i == tcsg_pkg::CODE_ROW) begin
      row_d = event_value_i;
      if (touch_q != tcsg_pkg::TOUCH_MAX) count_nx = touch_q + 2'd1;
    end
  end

  assign draw     = !clear_pressed_i && (count_nx >= tcsg_pkg::TOUCH_DRAW);
  assign q_push_o = accept && (clear_pressed_i || draw);
  assign touch_d  = draw ? '0 : count_nx;

  always_comb begin
    q_cmd_o.is_clear = clear_pressed_i;
    q_cmd_o.col      = col_d;
    q_cmd_o.row      = row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      touch_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      touch_q <= touch_d;
    end
  end

endmodule

// ===== sv/tcsg_cmd_fifo.sv =====
// Small job queue between front and back ends.
// Depends on tcsg_pkg for the job type and depth.
module tcsg_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcsg_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcsg_pkg::cmd_t cmd_o
);

  tcsg_pkg::cmd_t                  mem_q [tcsg_pkg::CMD_DEPTH];
  logic [tcsg_pkg::CMD_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [tcsg_pkg::CMD_CNT_W-1:0]  cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == tcsg_pkg::CMD_CNT_W'(tcsg_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== sv/tcsg_back.sv =====
// Back end: runs queued jobs, walking the box rows and emitting spans.
// One span is held back so the final one can carry last. Depends on tcsg_pkg.
module tcsg_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcsg_pkg::cfg_t                   cfg_i,
  input  logic                             cmd_valid_i,
  input  tcsg_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic [tcsg_pkg::COORD_BITS-1:0]  span_row_o,
  output logic [tcsg_pkg::COORD_BITS-1:0]  span_first_o,
  output logic [tcsg_pkg::COORD_BITS-1:0]  span_final_o,
  output logic [tcsg_pkg::COLOR_W-1:0]     fill_color_o,
  output logic                             last_o
);

  localparam int unsigned SW = tcsg_pkg::SW;
  localparam int unsigned CW = tcsg_pkg::COORD_BITS;

  tcsg_pkg::back_state_e state_q, state_d;

  logic signed [SW-1:0]  cc_q, cc_d, cr_q, cr_d;
  logic signed [SW-1:0]  y_q, y_d, y1_q, y1_d, x0_q, x0_d, x1_q, x1_d;
  logic [tcsg_pkg::H_W-1:0]   h_q, h_d, dx_q, dx_d;
  logic [tcsg_pkg::R2_W-1:0]  r2_q, r2_d;
  logic signed [tcsg_pkg::REM_W-1:0] rem_q, rem_d;
  logic          pend_v_q, pend_v_d;
  logic [CW-1:0] pend_row_q, pend_row_d, pend_a_q, pend_a_d, pend_b_q, pend_b_d;

  logic                         out_v_q, out_v_d, kind_q, kind_d, last_q, last_d;
  logic [CW-1:0]                row_o_q, row_o_d, first_q, first_d, final_q, final_d;
  logic [tcsg_pkg::COLOR_W-1:0] color_q, color_d;

  // Datapath terms
  logic [tcsg_pkg::DIAM_W-1:0]     d_cl;
  logic [2*tcsg_pkg::DIAM_W-1:0]   d_sq;
  logic signed [SW-1:0]            h_s, rlim, clim, y0_c, y1_c, x0_c, x1_c;
  logic signed [SW-1:0]            dy_full, dx_s, a_c, b_c;
  logic signed [tcsg_pkg::DY_W-1:0] dy;
  logic [tcsg_pkg::DY_W-1:0]       dy_abs;
  logic [2*tcsg_pkg::DY_W-1:0]     dy_sq;
  logic signed [tcsg_pkg::REM_W-1:0] rem_c;
  logic [tcsg_pkg::H_W-1:0]        dx_nx;
  logic [tcsg_pkg::SQ_W-1:0]       dx_nx_sq;
  logic                            dx_grow, row_done, span_empty, out_free;

  assign out_free = !out_v_q || !out_stall_i;

  always_comb begin
    d_cl = (cfg_i.diameter > tcsg_pkg::DIAM_LIMIT) ? tcsg_pkg::DIAM_LIMIT : cfg_i.diameter;
    d_sq = d_cl * d_cl;

    h_s  = $signed({{(SW-tcsg_pkg::H_W){1'b0}}, h_q});
    rlim = $signed({{(SW-tcsg_pkg::COLS_W){1'b0}}, cfg_i.rows}) - SW'(1);
    if (rlim > tcsg_pkg::COORD_MAX_S) rlim = tcsg_pkg::COORD_MAX_S;
    clim = $signed({{(SW-tcsg_pkg::COLS_W){1'b0}}, cfg_i.cols}) - SW'(1);
    if (clim > tcsg_pkg::COORD_MAX_S) clim = tcsg_pkg::COORD_MAX_S;

    y0_c = cr_q - h_s;
    if (y0_c < 0) y0_c = '0;
    y1_c = cr_q + h_s - SW'(1);
    if (y1_c > rlim) y1_c = rlim;
    x0_c = cc_q - h_s;
    if (x0_c < 0) x0_c = '0;
    x1_c = cc_q + h_s - SW'(1);
    if (x1_c > clim) x1_c = clim;

    // dy stays within +/- half-side, so a narrow square suffices
    dy_full = y_q - cr_q;
    dy      = dy_full[tcsg_pkg::DY_W-1:0];
    dy_abs  = dy[tcsg_pkg::DY_W-1] ? tcsg_pkg::DY_W'(-dy) : tcsg_pkg::DY_W'(dy);
    dy_sq   = dy_abs * dy_abs;
    rem_c   = $signed({1'b0, r2_q}) - $signed({1'b0, dy_sq[tcsg_pkg::R2_W-1:0]});
    row_done = (y_q > y1_q);

    dx_nx    = dx_q + tcsg_pkg::H_W'(1);
    dx_nx_sq = dx_nx * dx_nx;
    dx_grow  = (dx_q < h_q) && (dx_nx_sq <= tcsg_pkg::SQ_W'($unsigned(rem_q)));

    dx_s = $signed({{(SW-tcsg_pkg::H_W){1'b0}}, dx_q});
    a_c  = cc_q - dx_s;
    if (a_c < x0_q) a_c = x0_q;
    b_c  = cc_q + dx_s;
    if (b_c > x1_q) b_c = x1_q;
    span_empty = (a_c > b_c);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcsg_pkg::B_IDLE: begin
        if (cmd_valid_i) state_d = cmd_i.is_clear ? tcsg_pkg::B_CLR : tcsg_pkg::B_INIT;
      end
      tcsg_pkg::B_CLR: begin
        if (out_free) state_d = tcsg_pkg::B_IDLE;
      end
      tcsg_pkg::B_INIT: state_d = tcsg_pkg::B_ROW;
      tcsg_pkg::B_ROW: begin
        if (row_done)            state_d = tcsg_pkg::B_FLUSH;
        else if (!rem_c[tcsg_pkg::REM_W-1]) state_d = tcsg_pkg::B_DX;
      end
      tcsg_pkg::B_DX: begin
        if (!dx_grow) state_d = tcsg_pkg::B_SPAN;
      end
      tcsg_pkg::B_SPAN: begin
        if (span_empty || !pend_v_q || out_free) state_d = tcsg_pkg::B_ROW;
      end
      tcsg_pkg::B_FLUSH: begin
        if (!pend_v_q || out_free) state_d = tcsg_pkg::B_IDLE;
      end
      default: state_d = tcsg_pkg::B_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    cmd_pop_o  = 1'b0;
    cc_d = cc_q;  cr_d = cr_q;  h_d = h_q;  r2_d = r2_q;
    y_d  = y_q;   y1_d = y1_q;  x0_d = x0_q; x1_d = x1_q;
    rem_d = rem_q; dx_d = dx_q;
    pend_v_d = pend_v_q; pend_row_d = pend_row_q; pend_a_d = pend_a_q; pend_b_d = pend_b_q;
    out_v_d = out_v_q && out_stall_i;
    kind_d = kind_q; row_o_d = row_o_q; first_d = first_q; final_d = final_q;
    color_d = color_q; last_d = last_q;

    unique case (state_q)
      tcsg_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cc_d = $signed({{(SW-CW){1'b0}}, cmd_i.col});
          cr_d = $signed({{(SW-CW){1'b0}}, cmd_i.row});
          h_d  = d_cl[tcsg_pkg::DIAM_W-1:1];
          r2_d = d_sq[tcsg_pkg::R2_W+1:2];
        end
      end
      tcsg_pkg::B_CLR: begin
        if (out_free) begin
          out_v_d = 1'b1;
          kind_d  = tcsg_pkg::KIND_CLEAR;
          row_o_d = '0; first_d = '0; final_d = '0; color_d = '0;
          last_d  = 1'b1;
        end
      end
      tcsg_pkg::B_INIT: begin
        y_d  = y0_c;
        y1_d = y1_c;
        x0_d = x0_c;
        x1_d = x1_c;
        pend_v_d = 1'b0;
      end
      tcsg_pkg::B_ROW: begin
        if (!row_done) begin
          rem_d = rem_c;
          dx_d  = '0;
          if (rem_c[tcsg_pkg::REM_W-1]) y_d = y_q + SW'(1);
        end
      end
      tcsg_pkg::B_DX: begin
        if (dx_grow) dx_d = dx_nx;
      end
      tcsg_pkg::B_SPAN: begin
        if (span_empty) begin
          y_d = y_q + SW'(1);
        end else if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d = 1'b1;
            kind_d  = tcsg_pkg::KIND_SPAN;
            row_o_d = pend_row_q; first_d = pend_a_q; final_d = pend_b_q;
            color_d = cfg_i.color;
            last_d  = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_row_d = y_q[CW-1:0];
          pend_a_d   = a_c[CW-1:0];
          pend_b_d   = b_c[CW-1:0];
          y_d        = y_q + SW'(1);
        end
      end
      tcsg_pkg::B_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_v_d = 1'b1;
          kind_d  = tcsg_pkg::KIND_SPAN;
          row_o_d = pend_row_q; first_d = pend_a_q; final_d = pend_b_q;
          color_d = cfg_i.color;
          last_d  = 1'b1;
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tcsg_pkg::B_IDLE;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cc_q <= cc_d;  cr_q <= cr_d;  h_q <= h_d;  r2_q <= r2_d;
    y_q  <= y_d;   y1_q <= y1_d;  x0_q <= x0_d; x1_q <= x1_d;
    rem_q <= rem_d; dx_q <= dx_d;
    pend_row_q <= pend_row_d; pend_a_q <= pend_a_d; pend_b_q <= pend_b_d;
    kind_q <= kind_d; row_o_q <= row_o_d; first_q <= first_d; final_q <= final_d;
    color_q <= color_d; last_q <= last_d;
  end

  assign out_valid_o  = out_v_q;
  assign kind_o       = kind_q;
  assign span_row_o   = row_o_q;
  assign span_first_o = first_q;
  assign span_final_o = final_q;
  assign fill_color_o = color_q;
  assign last_o       = last_q;

endmodule

// ===== sv/touch_circle_span_generator_core.sv =====
// Top level of the touch circle span generator: config registers plus
// front end, job queue and back end. Depends on tcsg_pkg and the tcsg_* modules.
//
// Touch events arrive one per transfer on the input channel. Code 53 sets the
// centre column, code 54 the centre row, and each bumps a touch count that
// saturates at 3. A transfer with clear held yields one clear result (kind 1,
// zero span and color, last set) and keeps the count. Otherwise, once two or
// more touches are in, a draw job runs: the rows of the box of half-side
// diameter/2 around the centre are walked, clipped to the screen, and one
// span per non-empty row is sent out, the final one flagged with last; the
// count then returns to zero. A draw may produce no results at all. Rate: the
// front end takes an event every cycle while the two-entry job queue has
// room. The back end runs one job at a time: a clear goes from idle to a
// clear state that sends its result; a draw has a setup state, then for each
// row inside the circle a row state, a column-extent search that widens the
// span one step at a time up to the half-side, and a span state; that row
// walk and its one-step search loop set the throughput. Config registers are
// written through a separate always-ready channel and must only be changed
// while no job is pending.
module touch_circle_span_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input event channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tcsg_pkg::CODE_W-1:0]       event_code_i,
  input  logic [tcsg_pkg::COORD_BITS-1:0]   event_value_i,
  input  logic                              clear_pressed_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic [tcsg_pkg::COORD_BITS-1:0]   span_row_o,
  output logic [tcsg_pkg::COORD_BITS-1:0]   span_first_o,
  output logic [tcsg_pkg::COORD_BITS-1:0]   span_final_o,
  output logic [tcsg_pkg::COLOR_W-1:0]      fill_color_o,
  output logic                              last_o,
  // Config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcsg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tcsg_pkg::COLOR_W-1:0]      cfg_data_i
);

  tcsg_pkg::cfg_t cfg_q;
  tcsg_pkg::cmd_t push_cmd, pop_cmd;
  logic           q_full, q_push, q_pop, q_valid;

  // Config writes are always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diameter <= tcsg_pkg::DIAM_RST;
      cfg_q.cols     <= tcsg_pkg::COLS_RST;
      cfg_q.rows     <= tcsg_pkg::ROWS_RST;
      cfg_q.color    <= tcsg_pkg::COLOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tcsg_pkg::cfg_idx_e'(cfg_index_i))
        tcsg_pkg::CFG_DIAMETER: cfg_q.diameter <= cfg_data_i[tcsg_pkg::DIAM_W-1:0];
        tcsg_pkg::CFG_COLS:     cfg_q.cols     <= cfg_data_i[tcsg_pkg::COLS_W-1:0];
        tcsg_pkg::CFG_ROWS:     cfg_q.rows     <= cfg_data_i[tcsg_pkg::COLS_W-1:0];
        tcsg_pkg::CFG_COLOR:    cfg_q.color    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Event classification and centre tracking
  tcsg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .event_code_i   (event_code_i),
    .event_value_i  (event_value_i),
    .clear_pressed_i(clear_pressed_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  // Decouples event intake from span generation
  tcsg_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (pop_cmd)
  );

  // Row walker and result register
  tcsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .span_row_o  (span_row_o),
    .span_first_o(span_first_o),
    .span_final_o(span_final_o),
    .fill_color_o(fill_color_o),
    .last_o      (last_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for touch_circle_span_generator_core: drives touch events,
// writes config, and checks every span or clear result against a circle rasterizer.
// Depends on tcsg_pkg and the core RTL only.
module testbench;
  import tcsg_pkg::*;

  localparam int CLK_HALF      = 6;          // 12 ns period
  localparam int RESET_CYCLES  = 7;
  localparam int MAX_IDLE      = 18;         // longest random gap or stall, cycles
  localparam int SETTLE_CYCLES = 8000;       // covers two queued jobs plus one running
  localparam int HOLD_CYCLES   = 3000;       // long receiver hold-off
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int COORD_TOP     = (1 << COORD_BITS) - 1;
  localparam int DIAM_CAP      = MAX_DIAMETER;
  localparam int REPORT_MAX    = 10;

  // One result as seen on the output channel
  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] first_col;
    logic [COORD_BITS-1:0] last_col;
    logic [COLOR_W-1:0]    color;
    logic                  is_last;
  } span_rec_t;

  // Circle rasterizer plus queue of spans still owed by the block.
  class span_scoreboard;
    logic [DIAM_W-1:0]     diameter;
    logic [COLS_W-1:0]     cols;
    logic [COLS_W-1:0]     rows;
    logic [COLOR_W-1:0]    color;
    logic [COORD_BITS-1:0] ccol;
    logic [COORD_BITS-1:0] crow;
    logic [CNT_W-1:0]      touches;
    span_rec_t             owed_spans[$];
    int                    errors;

    function new();
      diameter = DIAM_RST;
      cols     = COLS_RST;
      rows     = ROWS_RST;
      color    = COLOR_RST;
      ccol     = '0;
      crow     = '0;
      touches  = '0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [COLOR_W-1:0] data);
      case (idx)
        CFG_DIAMETER: diameter = data[DIAM_W-1:0];
        CFG_COLS:     cols     = data[COLS_W-1:0];
        CFG_ROWS:     rows     = data[COLS_W-1:0];
        CFG_COLOR:    color    = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_spans.size();
    endfunction

    // Notes one accepted touch event and queues the results it causes.
    // Returns 0 when the event is simply ignored by the block.
    function bit note_event(logic [CODE_W-1:0] code, logic [COORD_BITS-1:0] value,
                            logic clr);
      int d, h, r2, cr, cc, y0, y1, x0, x1, rlim, clim, y, dy, rem, dx, a, b;
      span_rec_t held;
      bit have;
      bit useful;
      useful = clr || (code == CODE_COL) || (code == CODE_ROW);
      if (code == CODE_COL) begin
        ccol = value;
        if (touches < TOUCH_MAX) touches++;
      end else if (code == CODE_ROW) begin
        crow = value;
        if (touches < TOUCH_MAX) touches++;
      end
      // clear wins over a draw and leaves the count alone
      if (clr) begin
        held = '{KIND_CLEAR, '0, '0, '0, '0, 1'b1};
        owed_spans.push_back(held);
        return 1'b1;
      end
      if (touches < TOUCH_DRAW) return useful;

      d = int'(diameter);
      if (d > DIAM_CAP) d = DIAM_CAP;
      h  = d / 2;
      r2 = (d * d) / 4;
      cr = int'(crow);
      cc = int'(ccol);
      // box bounds, low side clamped at zero
      y0 = cr - h;
      if (y0 < 0) y0 = 0;
      y1 = cr + h - 1;
      x0 = cc - h;
      if (x0 < 0) x0 = 0;
      x1 = cc + h - 1;
      // clip to screen and to the coordinate range
      rlim = int'(rows) - 1;
      if (rlim > COORD_TOP) rlim = COORD_TOP;
      clim = int'(cols) - 1;
      if (clim > COORD_TOP) clim = COORD_TOP;
      if (y1 > rlim) y1 = rlim;
      if (x1 > clim) x1 = clim;

      // hold back one span so the final one can carry the last flag
      have = 1'b0;
      for (y = y0; y <= y1; y++) begin
        dy  = y - cr;
        rem = r2 - dy * dy;
        if (rem >= 0) begin
          dx = 0;
          while (dx < h && (dx + 1) * (dx + 1) <= rem) dx++;
          a = cc - dx;
          if (a < x0) a = x0;
          b = cc + dx;
          if (b > x1) b = x1;
          if (a <= b) begin
            if (have) owed_spans.push_back(held);
            held.kind      = KIND_SPAN;
            held.row       = COORD_BITS'(y);
            held.first_col = COORD_BITS'(a);
            held.last_col  = COORD_BITS'(b);
            held.color     = color;
            held.is_last   = 1'b0;
            have = 1'b1;
          end
        end
      end
      if (have) begin
        held.is_last = 1'b1;
        owed_spans.push_back(held);
      end
      touches = '0;
      return 1'b1;
    endfunction

    // Compares one accepted result against the oldest owed span.
    function void check_result(span_rec_t got);
      span_rec_t want;
      if (owed_spans.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $write("ERROR: result with nothing owed: kind %0d row %0d cols %0d..%0d",
                 got.kind, got.row, got.first_col, got.last_col);
          $display(" color %06h last %0d", got.color, got.is_last);
        end
        return;
      end
      want = owed_spans.pop_front();
      if (got.kind !== want.kind || got.row !== want.row ||
          got.first_col !== want.first_col || got.last_col !== want.last_col ||
          got.color !== want.color || got.is_last !== want.is_last) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $write("ERROR: expected kind %0d row %0d cols %0d..%0d color %06h last %0d,",
                 want.kind, want.row, want.first_col, want.last_col, want.color,
                 want.is_last);
          $display(" got kind %0d row %0d cols %0d..%0d color %06h last %0d",
                   got.kind, got.row, got.first_col, got.last_col,
                   got.color, got.is_last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_stall;
  logic [CODE_W-1:0]     event_code;
  logic [COORD_BITS-1:0] event_value;
  logic                  clear_pressed;
  logic                  out_valid;
  logic                  out_stall;
  logic                  kind;
  logic [COORD_BITS-1:0] span_row;
  logic [COORD_BITS-1:0] span_first;
  logic [COORD_BITS-1:0] span_final;
  logic [COLOR_W-1:0]    fill_color;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_e              cfg_index;
  logic [COLOR_W-1:0]    cfg_data;

  span_scoreboard sb = new();
  bit idle_on;            // random gaps and stalls on both channels
  int useful_items;       // accepted events that are not simply ignored
  int rx_hold_cycles;     // nonzero asks the receiver for a long hold-off

  touch_circle_span_generator_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .event_code_i    (event_code),
    .event_value_i   (event_value),
    .clear_pressed_i (clear_pressed),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .span_row_o      (span_row),
    .span_first_o    (span_first),
    .span_final_o    (span_final),
    .fill_color_o    (fill_color),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall before each transfer, long hold on request.
  // Outputs are sampled at the rising edge, stall changes at the falling edge.
  initial begin : receiver
    int waitn;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        waitn = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        waitn = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      @(negedge clk);
      if (waitn > 0) begin
        out_stall = 1'b1;
        repeat (waitn) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      // leave the wait early if a long hold is asked for
      while (out_valid !== 1'b1 && rx_hold_cycles == 0) @(posedge clk);
      if (out_valid === 1'b1)
        sb.check_result('{kind, span_row, span_first, span_final, fill_color, last});
    end
  end

  // Presents one event after an optional gap and waits for its transfer.
  // Valid stays high into the next call when that call has no gap.
  task automatic send_event(logic [CODE_W-1:0] code, logic [COORD_BITS-1:0] value,
                            logic clr);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    event_code    = code;
    event_value   = value;
    clear_pressed = clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_event(code, value, clr)) useful_items++;
  endtask

  // Sender goes quiet until every owed result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [COLOR_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only once the block is idle: drain, then let any
  // queued or running empty draws finish before touching them.
  task automatic set_config(logic [COLOR_W-1:0] diam, logic [COLOR_W-1:0] ncols,
                            logic [COLOR_W-1:0] nrows, logic [COLOR_W-1:0] rgb);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_DIAMETER, diam);
    write_reg(CFG_COLS, ncols);
    write_reg(CFG_ROWS, nrows);
    write_reg(CFG_COLOR, rgb);
  endtask

  // Mostly near the visible area so draws land on screen, sometimes anywhere
  function automatic logic [COORD_BITS-1:0] pick_coord(int extent);
    int top;
    top = extent + 8;
    if (top > COORD_TOP) top = COORD_TOP;
    if ($urandom_range(0, 9) < 8) return COORD_BITS'($urandom_range(0, top));
    return COORD_BITS'($urandom_range(0, COORD_TOP));
  endfunction

  // Column/row pair in random order: the sequence that actually draws
  task automatic send_touch_pair();
    logic [COORD_BITS-1:0] c, r;
    c = pick_coord(int'(sb.cols));
    r = pick_coord(int'(sb.rows));
    if ($urandom_range(0, 1) == 0) begin
      send_event(CODE_COL, c, 1'b0);
      send_event(CODE_ROW, r, 1'b0);
    end else begin
      send_event(CODE_ROW, r, 1'b0);
      send_event(CODE_COL, c, 1'b0);
    end
  endtask

  // Random traffic: mostly well-formed pairs, then clears, noise and
  // broken sequences (single touches, near-miss codes).
  task automatic run_random(int n_items);
    int goal, sel;
    logic [CODE_W-1:0] code;
    goal = useful_items + n_items;
    while (useful_items < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        drain_results();
      end else if (sel < 70) begin
        send_touch_pair();
      end else if (sel < 80) begin
        case ($urandom_range(0, 2))
          0:       code = CODE_COL;
          1:       code = CODE_ROW;
          default: code = CODE_W'($urandom_range(0, 16'hFFFF));
        endcase
        send_event(code, COORD_BITS'($urandom_range(0, COORD_TOP)), 1'b1);
      end else if (sel < 90) begin
        send_event(CODE_W'($urandom_range(0, 16'hFFFF)),
                   COORD_BITS'($urandom_range(0, COORD_TOP)), 1'b0);
      end else begin
        case ($urandom_range(0, 3))
          0:       code = CODE_COL;
          1:       code = CODE_ROW;
          2:       code = CODE_W'(CODE_COL - 1);
          default: code = CODE_W'(CODE_ROW + 1);
        endcase
        send_event(code, pick_coord(int'(sb.cols)), 1'(($urandom_range(0, 3) == 0)));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    in_valid       = 1'b0;
    event_code     = '0;
    event_value    = '0;
    clear_pressed  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_DIAMETER;
    cfg_data       = '0;
    idle_on        = 1'b1;
    useful_items   = 0;
    rx_hold_cycles = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset config (30 px, 800x480)
    send_event(CODE_COL, 12'd0, 1'b0);          // centre at origin: low bounds clamp
    send_event(CODE_ROW, 12'd0, 1'b0);
    send_event(CODE_COL, 12'd799, 1'b0);        // centre on the far corner: clipped
    send_event(CODE_ROW, 12'd479, 1'b0);
    send_event(CODE_COL, 12'd4095, 1'b0);       // fully off screen: empty draw
    send_event(CODE_ROW, 12'd4095, 1'b0);
    send_event(CODE_COL, 12'd300, 1'b0);        // same code twice still draws
    send_event(CODE_COL, 12'd320, 1'b0);
    send_event(CODE_ROW, 12'd240, 1'b0);
    send_event(CODE_ROW, 12'd250, 1'b0);
    send_event(16'd0, 12'd0, 1'b1);             // clear with no touches
    send_event(CODE_COL, 12'd200, 1'b1);        // clears keep the count...
    send_event(CODE_ROW, 12'd100, 1'b1);
    send_event(CODE_COL, 12'd210, 1'b1);        // ...which saturates at 3
    send_event(16'hFFFF, 12'd4095, 1'b0);       // ignored code, but count fires a draw
    send_event(CODE_W'(CODE_COL - 1), 12'd123, 1'b0);   // near-miss codes are ignored
    send_event(CODE_W'(CODE_ROW + 1), 12'd4095, 1'b0);
    send_event(16'd0, 12'd0, 1'b0);
    send_event(16'h8035, 12'hAAA, 1'b0);        // low byte matches, whole code does not
    send_event(CODE_ROW, 12'd5, 1'b0);
    send_event(CODE_COL, 12'd5, 1'b0);

    // Largest circle, widest screen; diameter written with junk upper bits
    set_config(24'hABCD40, 24'd4096, 24'd4096, 24'hFFFFFF);
    send_event(CODE_COL, 12'd2048, 1'b0);
    send_event(CODE_ROW, 12'd2048, 1'b0);
    send_event(CODE_COL, 12'd4095, 1'b0);       // clipped at the coordinate limit
    send_event(CODE_ROW, 12'd4095, 1'b0);
    send_event(CODE_COL, 12'd0, 1'b0);
    send_event(CODE_ROW, 12'd10, 1'b0);
    run_random(4);

    // Degenerate sizes: zero diameter and zero-size screen, then h = 0
    set_config(24'd0, 24'd0, 24'd0, 24'd0);
    run_random(8);
    set_config(24'd1, 24'd8191, 24'd8191, 24'($urandom));
    run_random(6);

    // Oversized diameter is capped at the max
    set_config(24'd127, 24'd100, 24'd60, 24'($urandom));
    run_random(8);

    // One-pixel-wide and one-pixel-tall screens
    set_config(24'd9, 24'd1, 24'd4096, 24'($urandom));
    run_random(8);
    set_config(24'd12, 24'd300, 24'd1, 24'($urandom));
    run_random(8);

    // Smallest real circle, back-to-back with no idling at all
    set_config(24'd2, 24'd800, 24'd480, 24'($urandom));
    idle_on = 1'b0;
    run_random(12);

    // Backpressure: receiver holds off while the sender keeps pushing draws,
    // so the job queue fills and the input stalls
    set_config(24'd20, 24'd200, 24'd200, 24'($urandom));
    drain_results();
    rx_hold_cycles = HOLD_CYCLES;
    for (k = 0; k < 8; k++) send_touch_pair();
    drain_results();
    idle_on = 1'b1;
    run_random(10);

    // Random settings, mostly small circles
    for (k = 0; k < 3; k++) begin
      set_config(24'($urandom_range(2, 24)), 24'($urandom_range(16, 1024)),
                 24'($urandom_range(16, 1024)), 24'($urandom));
      idle_on = ($urandom_range(0, 3) != 0);
      run_random(15);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tcsg_pkg.sv
sv/tcsg_front.sv
sv/tcsg_cmd_fifo.sv
sv/tcsg_back.sv
sv/touch_circle_span_generator_core.sv
tb/sv/testbench.sv
